// ===== sv/ljsw_pkg.sv =====
// Shared constants and types for the switched Lennard-Jones pair energy pipeline.
// No dependencies; the configuration interface and the top level import this package.
package ljsw_pkg;

    localparam int unsigned DIST_FRAC_BITS   = 10;
    localparam int unsigned RESULT_FRAC_BITS = 16;
    localparam int unsigned RATIO_FRAC       = 20;
    localparam int unsigned EMIN_FRAC        = 12;
    localparam int unsigned EN_SHIFT = EMIN_FRAC + RATIO_FRAC - RESULT_FRAC_BITS;
    localparam int unsigned DV_SHIFT = 32 - DIST_FRAC_BITS - RESULT_FRAC_BITS;

    localparam logic [15:0] CUT_ON_RST  = 16'd10240;
    localparam logic [15:0] CUT_OFF_RST = 16'd12288;
    localparam logic [31:0] POS_LIM     = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_LIM     = 32'h8000_0000;
    localparam logic [19:0] RATIO_CAP   = 20'd11;

    typedef enum logic {
        CFG_CUT_ON  = 1'b0,
        CFG_CUT_OFF = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SW_PASS,
        SW_SCALE,
        SW_ZERO
    } t_sw_mode;

    typedef struct packed {
        logic        zd;
        logic        cap;
        logic        eneg;
        logic [15:0] emag;
        t_sw_mode    mode;
        logic [15:0] pdist;
    } t_ctx;

    typedef struct packed {
        logic [31:0] en_mag;
        logic        en_neg;
        logic        en_sat;
        logic        dv_clip;
        logic        dv_neg;
    } t_tail;

endpackage

// ===== sv/ljsw_cfg_if.sv =====
// Configuration write channel: register index and write data with valid/ready.
// Depends on ljsw_pkg for the register index type.
interface ljsw_cfg_if;
    import ljsw_pkg::*;
    logic        valid;
    logic        ready;
    t_cfg_idx    index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/ljsw_in_if.sv =====
// Input channel carrying one atom pair per transaction.
// No dependencies.
interface ljsw_in_if;
    logic               valid;
    logic               ready;
    logic [15:0]        pair_distance;
    logic [15:0]        group_distance;
    logic [15:0]        rmin_pair;
    logic signed [15:0] emin_pair;
    modport source (output valid, output pair_distance, output group_distance,
                    output rmin_pair, output emin_pair, input ready);
    modport sink (input valid, input pair_distance, input group_distance,
                  input rmin_pair, input emin_pair, output ready);
endinterface

// ===== sv/ljsw_out_if.sv =====
// Result channel carrying energy, radial derivative and status flags.
// No dependencies.
interface ljsw_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] energy;
    logic signed [31:0] radial_derivative;
    logic               saturated;
    logic               zero_distance;
    modport source (output valid, output energy, output radial_derivative,
                    output saturated, output zero_distance, input ready);
    modport sink (input valid, input energy, input radial_derivative,
                  input saturated, input zero_distance, output ready);
endinterface

// ===== sv/ljsw_div_pipe.sv =====
// Pipelined restoring divider, QB/NS quotient bits per stage, one enable per stage.
// Requires the initial partial remainder to be below the divisor. No dependencies.
module ljsw_div_pipe #(
    parameter int unsigned QB = 32,
    parameter int unsigned DW = 16,
    parameter int unsigned NS = 8
) (
    input  logic          i_clk,
    input  logic [NS-1:0] i_en,
    input  logic [DW-1:0] i_rem0,
    input  logic [QB-1:0] i_lo,
    input  logic [DW-1:0] i_den,
    output logic [QB-1:0] o_quo
);
    localparam int unsigned BPS = QB / NS;

    logic [DW-1:0] r_rem [NS];
    logic [DW-1:0] r_den [NS];
    logic [QB-1:0] r_lo  [NS];
    logic [QB-1:0] r_quo [NS];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [DW-1:0] w_rem_in, w_den_in, v_rem;
        logic [QB-1:0] w_lo_in, w_quo_in, v_lo, v_quo;
        logic [DW:0]   v_t;

        if (s == 0) begin : g_first
            assign w_rem_in = i_rem0;
            assign w_den_in = i_den;
            assign w_lo_in  = i_lo;
            assign w_quo_in = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_den_in = r_den[s-1];
            assign w_lo_in  = r_lo[s-1];
            assign w_quo_in = r_quo[s-1];
        end

        always_comb begin
            v_rem = w_rem_in;
            v_lo  = w_lo_in;
            v_quo = w_quo_in;
            v_t   = '0;
            for (int b = 0; b < BPS; b++) begin
                v_t  = {v_rem, v_lo[QB-1]};
                v_lo = v_lo << 1;
                if (v_t >= {1'b0, w_den_in}) begin
                    v_t   = v_t - {1'b0, w_den_in};
                    v_quo = {v_quo[QB-2:0], 1'b1};
                end else begin
                    v_quo = {v_quo[QB-2:0], 1'b0};
                end
                v_rem = v_t[DW-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_rem[s] <= v_rem;
                r_den[s] <= w_den_in;
                r_lo[s]  <= v_lo;
                r_quo[s] <= v_quo;
            end
        end
    end

    assign o_quo = r_quo[NS-1];

endmodule

// ===== sv/ljsw_pow.sv =====
// Five-stage power chain: from the Q.20 ratio q it forms q^6 and q^12, each truncated.
// No dependencies; the enables come from the pipeline control of the top level.
module ljsw_pow (
    input  logic        i_clk,
    input  logic [4:0]  i_en,
    input  logic [23:0] i_q,
    output logic [40:0] o_p6,
    output logic [61:0] o_p12
);
    logic [47:0] w_qq;
    logic [26:0] r_q2;
    logic [23:0] r_q1;
    logic [50:0] w_q2q;
    logic [30:0] r_q3;
    logic [61:0] w_q33;
    logic [40:0] r_p6a, r_p6b, r_p6c;
    logic [19:0] w_h;
    logic [20:0] w_l;
    logic [39:0] r_hh;
    logic [40:0] r_hl;
    logic [41:0] r_ll;
    logic [81:0] w_sq;
    logic [61:0] r_p12;

    assign w_qq  = i_q * i_q;
    assign w_q2q = r_q2 * r_q1;
    assign w_q33 = r_q3 * r_q3;
    assign w_h   = r_p6a[40:21];
    assign w_l   = r_p6a[20:0];
    assign w_sq  = {r_hh, 42'b0} + {19'b0, r_hl, 22'b0} + {40'b0, r_ll};

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_q2 <= w_qq[46:20];
            r_q1 <= i_q;
        end
        if (i_en[1]) begin
            r_q3 <= w_q2q[50:20];
        end
        if (i_en[2]) begin
            r_p6a <= w_q33[60:20];
        end
        if (i_en[3]) begin
            r_hh  <= w_h * w_h;
            r_hl  <= w_h * w_l;
            r_ll  <= w_l * w_l;
            r_p6b <= r_p6a;
        end
        if (i_en[4]) begin
            r_p12 <= w_sq[81:20];
            r_p6c <= r_p6b;
        end
    end

    assign o_p6  = r_p6c;
    assign o_p12 = r_p12;

endmodule

// ===== sv/lennard_jones_switched_pair_energy.sv =====
// Switched 12-6 Lennard-Jones pair energy, top level of a 27-stage pipeline.
// Depends on ljsw_pkg, the three channel interfaces, ljsw_div_pipe and ljsw_pow.
//
// Usage: each transaction on i_in carries one atom pair (pair distance, group
// distance, Rmin, Emin). Each produces exactly one transaction on o_out with the
// switched energy, the unswitched radial derivative and the two status flags.
// i_cfg writes cut_on (index 0) or cut_off (index 1); it is always ready and
// must only be used while the pipeline is empty.
// The pipeline takes one pair per cycle unless the receiver stalls it; the
// restoring dividers (ratio, switching terms and derivative) are pipelined, each eight stages deep.
// Every stage holds a valid bit and advances whenever it is empty or the stage
// after it advances, so bubbles are squeezed out and a stalled receiver only
// holds back what is queued behind the result register. When all stages are
// full and o_out.ready is low, i_in.ready drops.
// Reset empties the pipeline and loads cut_on = 10.0 and cut_off = 12.0 angstrom.
module lennard_jones_switched_pair_energy (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ljsw_cfg_if.sink   i_cfg,
    ljsw_in_if.sink    i_in,
    ljsw_out_if.source o_out
);
    import ljsw_pkg::*;

    localparam int unsigned NST = 27;

    logic [NST-1:0] r_v;
    logic [NST-1:0] w_en;
    logic [15:0]    r_cut_on, r_cut_off;

    t_ctx        r_ctx [NST-1];
    t_ctx        n_ctx0;
    logic [15:0] n_c0, n_a0, r_c0, r_a0, r_r0;
    logic [17:0] n_b0, r_b0;

    logic [23:0] w_q;
    logic [31:0] w_x, w_y;
    logic [63:0] w_xx, w_sw;
    logic [31:0] r_xx, r_y9;
    logic [31:0] r_sw [10:16];

    logic [40:0] w_p6;
    logic [61:0] w_p12, w_two6, w_p6e;
    logic [61:0] n_tm, n_um, r_tm, r_um;
    logic        n_tneg, n_uneg, r_tneg14, r_uneg14, r_tneg15, r_uneg15;

    logic [18:0] w_k;
    logic [46:0] w_ehi, w_elo, r_ehi, r_elo;
    logic [49:0] w_dhi, w_dlo, r_dhi, r_dlo;

    logic [77:0] w_eprod;
    logic [61:0] w_esh;
    logic [80:0] w_dprod;
    logic [74:0] r_nd;
    logic        w_enneg;
    logic [31:0] w_elim;
    t_ctx        c15;
    logic [31:0] n_enmag, r_enmag;
    logic        n_enneg, n_esat, r_enneg, r_esat, r_dvneg16;

    t_ctx        c16;
    logic [63:0] w_scl;
    logic [47:0] w_thr;
    t_tail       n_tail17;
    t_tail       r_tail [17:25];
    logic [15:0] r_drem0;
    logic [31:0] r_dlo32;
    logic [31:0] w_dq;

    t_ctx        c25;
    t_tail       t25;
    logic        w_ovr;
    logic        n_dvneg, n_sat;
    logic [31:0] n_dvmag, n_energy, n_deriv;
    logic [31:0] r_energy, r_deriv;
    logic        r_sat, r_zd;

    // Pipeline advance chain.
    always_comb begin
        w_en[NST-1] = !r_v[NST-1] || o_out.ready;
        for (int k = NST - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign i_in.ready  = w_en[0];
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v       <= '0;
            r_cut_on  <= CUT_ON_RST;
            r_cut_off <= CUT_OFF_RST;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_in.valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_CUT_ON:  r_cut_on  <= i_cfg.data;
                    CFG_CUT_OFF: r_cut_off <= i_cfg.data;
                    default:     r_cut_on  <= r_cut_on;
                endcase
            end
        end
    end

    // Stage 0: decode the pair and prepare the divider operands.
    always_comb begin
        n_ctx0.eneg  = i_in.emin_pair[15];
        n_ctx0.emag  = n_ctx0.eneg ? (16'd0 - $unsigned(i_in.emin_pair))
                                   : $unsigned(i_in.emin_pair);
        n_ctx0.zd    = (i_in.pair_distance == 16'd0);
        n_ctx0.cap   = ({4'b0, i_in.rmin_pair} >= ({4'b0, i_in.pair_distance} * RATIO_CAP));
        n_ctx0.pdist = i_in.pair_distance;
        n_c0 = r_cut_off - r_cut_on;
        n_a0 = r_cut_off - i_in.group_distance;
        n_b0 = {2'b0, n_c0} + {1'b0, i_in.group_distance - r_cut_on, 1'b0};
        priority if (i_in.group_distance > r_cut_off) begin
            n_ctx0.mode = SW_ZERO;
        end else if (i_in.group_distance > r_cut_on) begin
            n_ctx0.mode = SW_SCALE;
        end else begin
            n_ctx0.mode = SW_PASS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_ctx[0] <= n_ctx0;
            r_r0     <= i_in.rmin_pair;
            r_a0     <= n_a0;
            r_b0     <= n_b0;
            r_c0     <= n_c0;
        end
        for (int k = 1; k < NST - 1; k++) begin
            if (w_en[k]) begin
                r_ctx[k] <= r_ctx[k-1];
            end
        end
    end

    // Stages 1 to 8: ratio and switching quotients.
    ljsw_div_pipe #(.QB(24), .DW(16), .NS(8)) u_qdiv (
        .i_clk  (i_clk),
        .i_en   (w_en[8:1]),
        .i_rem0 ({4'b0, r_r0[15:4]}),
        .i_lo   ({r_r0[3:0], 20'b0}),
        .i_den  (r_ctx[0].pdist),
        .o_quo  (w_q)
    );

    ljsw_div_pipe #(.QB(32), .DW(16), .NS(8)) u_xdiv (
        .i_clk  (i_clk),
        .i_en   (w_en[8:1]),
        .i_rem0 ({2'b0, r_a0[15:2]}),
        .i_lo   ({r_a0[1:0], 30'b0}),
        .i_den  (r_c0),
        .o_quo  (w_x)
    );

    ljsw_div_pipe #(.QB(32), .DW(16), .NS(8)) u_ydiv (
        .i_clk  (i_clk),
        .i_en   (w_en[8:1]),
        .i_rem0 (r_b0[17:2]),
        .i_lo   ({r_b0[1:0], 30'b0}),
        .i_den  (r_c0),
        .o_quo  (w_y)
    );

    // Stages 9 to 13: powers of the ratio.
    ljsw_pow u_pow (
        .i_clk (i_clk),
        .i_en  (w_en[13:9]),
        .i_q   (w_q),
        .o_p6  (w_p6),
        .o_p12 (w_p12)
    );

    // Stages 9 and 10: switching factor, then delayed to stage 16.
    assign w_xx = w_x * w_x;
    assign w_sw = r_xx * r_y9;

    always_ff @(posedge i_clk) begin
        if (w_en[9]) begin
            r_xx <= w_xx[61:30];
            r_y9 <= w_y;
        end
        if (w_en[10]) begin
            r_sw[10] <= w_sw[61:30];
        end
        for (int k = 11; k <= 16; k++) begin
            if (w_en[k]) begin
                r_sw[k] <= r_sw[k-1];
            end
        end
    end

    // Stage 14: differences of the powers.
    assign w_two6 = {20'b0, w_p6, 1'b0};
    assign w_p6e  = {21'b0, w_p6};

    always_comb begin
        n_tneg = (w_p12 < w_two6);
        n_tm   = n_tneg ? (w_two6 - w_p12) : (w_p12 - w_two6);
        n_uneg = (w_p12 < w_p6e);
        n_um   = n_uneg ? (w_p6e - w_p12) : (w_p12 - w_p6e);
    end

    // Stage 15: partial products with Emin and 12*Emin.
    assign w_k   = {r_ctx[14].emag, 3'b0} + {1'b0, r_ctx[14].emag, 2'b0};
    assign w_ehi = r_tm[61:31] * r_ctx[14].emag;
    assign w_elo = r_tm[30:0] * r_ctx[14].emag;
    assign w_dhi = r_um[61:31] * w_k;
    assign w_dlo = r_um[30:0] * w_k;

    // Stage 16: energy clipping and derivative numerator.
    assign c15     = r_ctx[15];
    assign w_eprod = {r_ehi, 31'b0} + {31'b0, r_elo};
    assign w_esh   = w_eprod[77:EN_SHIFT];
    assign w_dprod = {r_dhi, 31'b0} + {31'b0, r_dlo};
    assign w_enneg = c15.eneg ^ r_tneg15;
    assign w_elim  = w_enneg ? NEG_LIM : POS_LIM;

    always_comb begin
        priority if (c15.zd || (c15.cap && (c15.emag != 16'd0))) begin
            n_enneg = c15.eneg;
            n_enmag = c15.eneg ? NEG_LIM : POS_LIM;
            n_esat  = 1'b1;
        end else if (c15.cap) begin
            n_enneg = 1'b0;
            n_enmag = '0;
            n_esat  = 1'b0;
        end else if (w_esh > {30'b0, w_elim}) begin
            n_enneg = w_enneg;
            n_enmag = w_elim;
            n_esat  = 1'b1;
        end else begin
            n_enneg = w_enneg;
            n_enmag = w_esh[31:0];
            n_esat  = 1'b0;
        end
    end

    // Stage 17: switched energy and derivative clip test.
    assign c16   = r_ctx[16];
    assign w_scl = r_enmag * r_sw[16];
    assign w_thr = {1'b0, c16.pdist, 31'b0} + (r_dvneg16 ? {32'b0, c16.pdist} : 48'd0);

    always_comb begin
        n_tail17.en_neg  = r_enneg;
        n_tail17.en_sat  = r_esat;
        n_tail17.dv_neg  = r_dvneg16;
        n_tail17.dv_clip = (r_nd >= {27'b0, w_thr});
        unique case (c16.mode)
            SW_ZERO:  n_tail17.en_mag = '0;
            SW_SCALE: n_tail17.en_mag = w_scl[61:30];
            default:  n_tail17.en_mag = r_enmag;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en[14]) begin
            r_tm     <= n_tm;
            r_um     <= n_um;
            r_tneg14 <= n_tneg;
            r_uneg14 <= n_uneg;
        end
        if (w_en[15]) begin
            r_ehi    <= w_ehi;
            r_elo    <= w_elo;
            r_dhi    <= w_dhi;
            r_dlo    <= w_dlo;
            r_tneg15 <= r_tneg14;
            r_uneg15 <= r_uneg14;
        end
        if (w_en[16]) begin
            r_enmag   <= n_enmag;
            r_enneg   <= n_enneg;
            r_esat    <= n_esat;
            r_nd      <= w_dprod[80:DV_SHIFT];
            r_dvneg16 <= (c15.eneg == r_uneg15);
        end
        if (w_en[17]) begin
            r_tail[17] <= n_tail17;
            r_drem0    <= r_nd[47:32];
            r_dlo32    <= r_nd[31:0];
        end
        for (int k = 18; k <= 25; k++) begin
            if (w_en[k]) begin
                r_tail[k] <= r_tail[k-1];
            end
        end
    end

    // Stages 18 to 25: derivative quotient.
    ljsw_div_pipe #(.QB(32), .DW(16), .NS(8)) u_ddiv (
        .i_clk  (i_clk),
        .i_en   (w_en[25:18]),
        .i_rem0 (r_drem0),
        .i_lo   (r_dlo32),
        .i_den  (r_ctx[17].pdist),
        .o_quo  (w_dq)
    );

    // Stage 26: result register.
    assign c25   = r_ctx[25];
    assign t25   = r_tail[25];
    assign w_ovr = c25.zd || (c25.cap && (c25.emag != 16'd0));

    always_comb begin
        priority if (w_ovr) begin
            n_dvneg = !c25.eneg;
            n_dvmag = c25.eneg ? POS_LIM : NEG_LIM;
            n_sat   = 1'b1;
        end else if (c25.cap) begin
            n_dvneg = 1'b0;
            n_dvmag = '0;
            n_sat   = 1'b0;
        end else if (t25.dv_clip) begin
            n_dvneg = t25.dv_neg;
            n_dvmag = t25.dv_neg ? NEG_LIM : POS_LIM;
            n_sat   = 1'b1;
        end else begin
            n_dvneg = t25.dv_neg;
            n_dvmag = w_dq;
            n_sat   = t25.en_sat;
        end
        n_energy = t25.en_neg ? (32'd0 - t25.en_mag) : t25.en_mag;
        n_deriv  = n_dvneg ? (32'd0 - n_dvmag) : n_dvmag;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NST-1]) begin
            r_energy <= n_energy;
            r_deriv  <= n_deriv;
            r_sat    <= n_sat | t25.en_sat;
            r_zd     <= c25.zd;
        end
    end

    assign o_out.valid             = r_v[NST-1];
    assign o_out.energy            = r_energy;
    assign o_out.radial_derivative = r_deriv;
    assign o_out.saturated         = r_sat;
    assign o_out.zero_distance     = r_zd;

    a_zd_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.zero_distance) |-> o_out.saturated)
        else $error("zero distance result without saturation flag");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_v[0])
        else $error("accepted transaction did not enter the first stage");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_v[0] && r_v[NST-1] && !o_out.ready))
        else $error("input stalled while the pipeline could advance");

endmodule
